/* design/ihcv_pkg.sv */
// Shared types, codes and the CRC-32 byte step for the image header CRC verifier.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ihcv_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_MAGIC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_VERSION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HDR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT    = 3'd4;

    // register reset values
    localparam logic [31:0] SLOT_SIZE_RST   = 32'd65536;
    localparam logic [31:0] IMAGE_MAGIC_RST = 32'd0;
    localparam logic [31:0] HDR_VERSION_RST = 32'd1;
    localparam logic [15:0] MIN_HDR_RST     = 16'd20;
    localparam logic [31:0] CRC_INIT_RST    = 32'hFFFF_FFFF;

    // input operation codes
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_DATA   = 1'b1;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_VERIFY   = 2'd1;
    localparam status_t ST_READ_ERR = 2'd2;

    // command kinds decided by the front end
    typedef logic [2:0] cmd_kind_t;
    localparam cmd_kind_t CMD_HDR_OK   = 3'd0;
    localparam cmd_kind_t CMD_HDR_BAD  = 3'd1;
    localparam cmd_kind_t CMD_HDR_FAIL = 3'd2;
    localparam cmd_kind_t CMD_DATA     = 3'd3;
    localparam cmd_kind_t CMD_DATA_FAIL = 3'd4;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] image_bytes;
        logic [31:0] expected_crc;
        logic [7:0]  data_byte;
    } cmd_t;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] byte_in);
        logic [31:0] c;
        c = crc_in ^ {24'd0, byte_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/image_header_crc_verifier.sv */
// Image header and CRC-32 verifier, top level.
// Depends on ihcv_pkg, ihcv_front, ihcv_queue and ihcv_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries header items (operation 0) and
//   image data bytes (operation 1). A header is checked on arrival; a bad or
//   unreadable header gives one result. A good header arms a CRC run over
//   image_bytes data bytes; the last byte gives status and final CRC.
//   Configuration channel (cfg_valid/cfg_ready) writes the slot size, magic,
//   version, minimum header size and CRC init; it is always ready. Write it
//   only while no item is in flight.
//   Throughput: one item per cycle while the command queue is not full, set
//   by the byte-wide CRC step. With the queue empty and the result register
//   free, an item passes through the command queue, then the result register.
//   Output stalls: the result register holds until out_ready; items keep
//   entering a QUEUE_DEPTH-entry command queue, and in_ready drops only
//   when that queue is full.
//   Reset: registers return to their defaults, the queue empties, the block
//   is idle and no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module image_header_crc_verifier #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ihcv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                     cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            operation,
    input  wire logic [31:0]                     magic,
    input  wire logic [31:0]                     version,
    input  wire logic [31:0]                     header_bytes,
    input  wire logic [31:0]                     image_bytes,
    input  wire logic [31:0]                     expected_crc,
    input  wire logic [7:0]                      data_byte,
    input  wire logic                            read_failed,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0]                           status,
    output logic [31:0]                          computed_crc
);
    import ihcv_pkg::*;

    logic        q_full;
    logic        q_push;
    cmd_t        q_cmd;
    cmd_t        head_cmd;
    logic        head_valid;
    logic        q_pop;
    logic [31:0] crc_init;

    ihcv_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .magic        (magic),
        .version      (version),
        .header_bytes (header_bytes),
        .image_bytes  (image_bytes),
        .expected_crc (expected_crc),
        .data_byte    (data_byte),
        .read_failed  (read_failed),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd),
        .crc_init     (crc_init)
    );

    ihcv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid)
    );

    ihcv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .crc_init     (crc_init),
        .head_cmd     (head_cmd),
        .head_valid   (head_valid),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .computed_crc (computed_crc)
    );

endmodule

`default_nettype wire

/* design/ihcv_front.sv */
// Front end: configuration registers, input transfer and header classification.
// Depends on ihcv_pkg; pushes one command per accepted item into ihcv_queue.
`timescale 1ns / 1ps
`default_nettype none

module ihcv_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ihcv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                     cfg_data,
    // input items
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            operation,
    input  wire logic [31:0]                     magic,
    input  wire logic [31:0]                     version,
    input  wire logic [31:0]                     header_bytes,
    input  wire logic [31:0]                     image_bytes,
    input  wire logic [31:0]                     expected_crc,
    input  wire logic [7:0]                      data_byte,
    input  wire logic                            read_failed,
    // to queue
    input  wire logic                            q_full,
    output logic                                 q_push,
    output ihcv_pkg::cmd_t                       q_cmd,
    // to back end
    output logic [31:0]                          crc_init
);
    import ihcv_pkg::*;

    logic [31:0] slot_size_reg;
    logic [31:0] image_magic_reg;
    logic [31:0] hdr_version_reg;
    logic [15:0] min_hdr_reg;
    logic [31:0] crc_init_reg;

    logic [31:0] min_hdr_ext;
    logic [31:0] room;
    logic        hdr_ok;

    assign cfg_ready = 1'b1;
    assign crc_init  = crc_init_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_size_reg   <= SLOT_SIZE_RST;
            image_magic_reg <= IMAGE_MAGIC_RST;
            hdr_version_reg <= HDR_VERSION_RST;
            min_hdr_reg     <= MIN_HDR_RST;
            crc_init_reg    <= CRC_INIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SLOT_SIZE:   slot_size_reg   <= cfg_data;
                REG_IMAGE_MAGIC: image_magic_reg <= cfg_data;
                REG_HDR_VERSION: hdr_version_reg <= cfg_data;
                REG_MIN_HDR:     min_hdr_reg     <= cfg_data[15:0];
                REG_CRC_INIT:    crc_init_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // header checks; room only matters once header_bytes < slot_size holds
    assign min_hdr_ext = {16'd0, min_hdr_reg};
    assign room        = slot_size_reg - header_bytes;
    assign hdr_ok      = (slot_size_reg > min_hdr_ext)
                      && (magic == image_magic_reg)
                      && (header_bytes >= min_hdr_ext)
                      && (header_bytes[1:0] == 2'b00)
                      && (header_bytes < slot_size_reg)
                      && (version == hdr_version_reg)
                      && (image_bytes != 32'd0)
                      && (image_bytes <= room);

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        q_cmd.image_bytes  = image_bytes;
        q_cmd.expected_crc = expected_crc;
        q_cmd.data_byte    = data_byte;
        if (operation == OP_HEADER)
        begin
            if (read_failed)
                q_cmd.kind = CMD_HDR_FAIL;
            else if (hdr_ok)
                q_cmd.kind = CMD_HDR_OK;
            else
                q_cmd.kind = CMD_HDR_BAD;
        end
        else
        begin
            q_cmd.kind = read_failed ? CMD_DATA_FAIL : CMD_DATA;
        end
    end

endmodule

`default_nettype wire

/* design/ihcv_queue.sv */
// Short command queue between front end and back end.
// Depends on ihcv_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module ihcv_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire ihcv_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output ihcv_pkg::cmd_t      head_cmd,
    output logic                head_valid
);
    import ihcv_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    cmd_t          slots [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == FULL_COUNT);
    assign head_cmd   = slots[rd_ptr_reg];

    // pointers wrap at DEPTH, which need not be a power of two
    assign wr_ptr_next = !push ? wr_ptr_reg
                       : (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = !pop ? rd_ptr_reg
                       : (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

/* design/ihcv_back.sv */
// Back end: run state, CRC byte engine and the result register.
// Depends on ihcv_pkg; consumes commands from ihcv_queue.
`timescale 1ns / 1ps
`default_nettype none

module ihcv_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [31:0]         crc_init,
    input  wire ihcv_pkg::cmd_t      head_cmd,
    input  wire logic                head_valid,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ihcv_pkg::status_t        status,
    output logic [31:0]              computed_crc
);
    import ihcv_pkg::*;

    logic        busy_reg, busy_next;
    logic [31:0] running_crc_reg, running_crc_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [31:0] target_crc_reg, target_crc_next;
    logic        out_valid_reg;
    status_t     status_reg;
    logic [31:0] crc_out_reg;

    logic        emit;
    status_t     emit_status;
    logic [31:0] emit_crc;
    logic [31:0] crc_step;
    logic [31:0] crc_final;

    // result slot free now or freed by this cycle's output transfer
    assign pop = head_valid && (!out_valid_reg || out_ready);

    assign crc_step  = crc_byte(running_crc_reg, head_cmd.data_byte);
    assign crc_final = crc_step ^ crc_init;

    always_comb
    begin
        busy_next        = busy_reg;
        running_crc_next = running_crc_reg;
        bytes_left_next  = bytes_left_reg;
        target_crc_next  = target_crc_reg;
        emit             = 1'b0;
        emit_status      = ST_OK;
        emit_crc         = 32'd0;
        if (pop)
        begin
            unique case (head_cmd.kind)
                CMD_HDR_FAIL:
                begin
                    busy_next   = 1'b0;
                    emit        = 1'b1;
                    emit_status = ST_READ_ERR;
                end
                CMD_HDR_BAD:
                begin
                    busy_next   = 1'b0;
                    emit        = 1'b1;
                    emit_status = ST_VERIFY;
                end
                CMD_HDR_OK:
                begin
                    busy_next        = 1'b1;
                    running_crc_next = crc_init;
                    bytes_left_next  = head_cmd.image_bytes;
                    target_crc_next  = head_cmd.expected_crc;
                end
                CMD_DATA_FAIL:
                begin
                    if (busy_reg)
                    begin
                        busy_next   = 1'b0;
                        emit        = 1'b1;
                        emit_status = ST_READ_ERR;
                    end
                end
                CMD_DATA:
                begin
                    if (busy_reg)
                    begin
                        running_crc_next = crc_step;
                        bytes_left_next  = bytes_left_reg - 32'd1;
                        // last counted byte closes the run
                        if (bytes_left_reg == 32'd1)
                        begin
                            busy_next   = 1'b0;
                            emit        = 1'b1;
                            emit_crc    = crc_final;
                            emit_status = (crc_final == target_crc_reg) ? ST_OK : ST_VERIFY;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (pop && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        running_crc_reg <= running_crc_next;
        bytes_left_reg  <= bytes_left_next;
        target_crc_reg  <= target_crc_next;
        if (pop && emit)
        begin
            status_reg  <= emit_status;
            crc_out_reg <= emit_crc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign computed_crc = crc_out_reg;

endmodule

`default_nettype wire

/* tb/ihcv_checker.sv */
// Result checker for the image header CRC verifier testbench.
// Tracks register writes and input transfers, predicts each result and compares it.
// Depends on ihcv_pkg for register indexes, operation and status codes.
`timescale 1ns / 1ps

module ihcv_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [ihcv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           operation,
    input  logic [31:0]                    magic,
    input  logic [31:0]                    version,
    input  logic [31:0]                    header_bytes,
    input  logic [31:0]                    image_bytes,
    input  logic [31:0]                    expected_crc,
    input  logic [7:0]                     data_byte,
    input  logic                           read_failed,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [1:0]                     status,
    input  logic [31:0]                    computed_crc,
    output int                             mismatches,
    output int                             outstanding
);

    import ihcv_pkg::*;

    typedef struct packed {
        status_t     st;
        logic [31:0] crc;
    } verdict_t;

    logic [31:0] slot_size_r;
    logic [31:0] magic_r;
    logic [31:0] version_r;
    logic [15:0] min_hdr_r;
    logic [31:0] crc_init_r;

    logic [31:0] run_crc;
    logic [31:0] bytes_to_go;
    logic [31:0] crc_wanted;
    logic        armed;

    verdict_t    expected_verdicts [$];

    // bit-serial reflected CRC: feed one data bit per shift
    function automatic logic [31:0] crc_advance(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            c = {1'b0, c[31:1]} ^ ({32{c[0] ^ b[i]}} & CRC_POLY);
        end
        return c;
    endfunction

    function automatic logic header_valid(input logic [31:0] mg, input logic [31:0] ver,
                                          input logic [31:0] hdr, input logic [31:0] img);
        if (slot_size_r <= {16'd0, min_hdr_r})
            return 1'b0;
        if (mg != magic_r || ver != version_r)
            return 1'b0;
        if (hdr < {16'd0, min_hdr_r} || hdr[1:0] != 2'b00 || hdr >= slot_size_r)
            return 1'b0;
        // hdr < slot here, so the subtraction cannot wrap
        if (img == 32'd0 || img > slot_size_r - hdr)
            return 1'b0;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        verdict_t    want;
        logic [31:0] fin;
        if (!rst_n)
        begin
            slot_size_r = SLOT_SIZE_RST;
            magic_r     = IMAGE_MAGIC_RST;
            version_r   = HDR_VERSION_RST;
            min_hdr_r   = MIN_HDR_RST;
            crc_init_r  = CRC_INIT_RST;
            run_crc     = CRC_INIT_RST;
            bytes_to_go = 32'd0;
            crc_wanted  = 32'd0;
            armed       = 1'b0;
            expected_verdicts.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SLOT_SIZE:   slot_size_r = cfg_data;
                    REG_IMAGE_MAGIC: magic_r = cfg_data;
                    REG_HDR_VERSION: version_r = cfg_data;
                    REG_MIN_HDR:     min_hdr_r = cfg_data[15:0];
                    REG_CRC_INIT:    crc_init_r = cfg_data;
                    default:         ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                if (operation == OP_HEADER)
                begin
                    // any run in progress is dropped silently
                    armed = 1'b0;
                    bytes_to_go = 32'd0;
                    if (read_failed)
                        expected_verdicts.push_back({ST_READ_ERR, 32'd0});
                    else if (!header_valid(magic, version, header_bytes, image_bytes))
                        expected_verdicts.push_back({ST_VERIFY, 32'd0});
                    else
                    begin
                        run_crc = crc_init_r;
                        bytes_to_go = image_bytes;
                        crc_wanted = expected_crc;
                        armed = 1'b1;
                    end
                end
                else if (armed)
                begin
                    if (read_failed)
                    begin
                        armed = 1'b0;
                        bytes_to_go = 32'd0;
                        expected_verdicts.push_back({ST_READ_ERR, 32'd0});
                    end
                    else
                    begin
                        run_crc = crc_advance(run_crc, data_byte);
                        bytes_to_go = bytes_to_go - 32'd1;
                        if (bytes_to_go == 32'd0)
                        begin
                            // final XOR uses the init value current at the last byte
                            fin = run_crc ^ crc_init_r;
                            armed = 1'b0;
                            if (fin == crc_wanted)
                                expected_verdicts.push_back({ST_OK, fin});
                            else
                                expected_verdicts.push_back({ST_VERIFY, fin});
                        end
                    end
                end
            end

            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result: status %0d crc %08h",
                                 $time, status, computed_crc);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (status !== want.st || computed_crc !== want.crc)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result mismatch: status exp %0d got %0d, crc exp %08h got %08h",
                                     $time, want.st, status, want.crc, computed_crc);
                    end
                end
            end

            outstanding = expected_verdicts.size();
        end
    end

endmodule

/* tb/image_header_crc_verifier_tb.sv */
// Top of the image header CRC verifier testbench: clock, reset, stimulus and verdict.
// Drives the config, input and result channels; ihcv_checker does the prediction.
// Depends on ihcv_pkg, ihcv_checker and the image_header_crc_verifier RTL.
`timescale 1ns / 1ps

module image_header_crc_verifier_tb;

    import ihcv_pkg::*;

    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 10;
    localparam int TIMEOUT_NS    = 5_000_000;

    typedef struct {
        logic        op;
        logic [31:0] mg;
        logic [31:0] ver;
        logic [31:0] hdr;
        logic [31:0] img;
        logic [31:0] crc;
        logic [7:0]  db;
        logic        fail;
    } item_t;

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [31:0]          cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic                 operation    = OP_HEADER;
    logic [31:0]          magic        = '0;
    logic [31:0]          version      = '0;
    logic [31:0]          header_bytes = '0;
    logic [31:0]          image_bytes  = '0;
    logic [31:0]          expected_crc = '0;
    logic [7:0]           data_byte    = '0;
    logic                 read_failed  = 1'b0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic [1:0]           status;
    logic [31:0]          computed_crc;

    int  mismatches;
    int  outstanding;

    // sender-side view of the registers, used to build well-formed headers
    logic [31:0] slot_cfg  = SLOT_SIZE_RST;
    logic [31:0] magic_cfg = IMAGE_MAGIC_RST;
    logic [31:0] ver_cfg   = HDR_VERSION_RST;
    logic [15:0] min_cfg   = MIN_HDR_RST;
    logic [31:0] init_cfg  = CRC_INIT_RST;

    int   sent        = 0;
    int   steady_left = 0;
    bit   no_gap      = 1'b0;
    logic hold_req    = 1'b0;

    image_header_crc_verifier uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .magic        (magic),
        .version      (version),
        .header_bytes (header_bytes),
        .image_bytes  (image_bytes),
        .expected_crc (expected_crc),
        .data_byte    (data_byte),
        .read_failed  (read_failed),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .computed_crc (computed_crc)
    );

    ihcv_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .magic        (magic),
        .version      (version),
        .header_bytes (header_bytes),
        .image_bytes  (image_bytes),
        .expected_crc (expected_crc),
        .data_byte    (data_byte),
        .read_failed  (read_failed),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .computed_crc (computed_crc),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("image_header_crc_verifier_tb: FAIL");
        $finish;
    end

    // result side: steady stretches, short and long stalls, one long hold on request
    initial
    begin : receiver
        int stall_left;
        int ready_left;
        int r;
        bit hold_served;
        stall_left = 0;
        ready_left = 0;
        hold_served = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_served)
            begin
                hold_served = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (!hold_req)
                    hold_served = 1'b0;
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ready <= 1'b0;
                end
                else if (ready_left > 0)
                begin
                    ready_left--;
                    out_ready <= 1'b1;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 10)
                    begin
                        ready_left = $urandom_range(20, 120);
                        out_ready <= 1'b1;
                    end
                    else if (r < 45)
                    begin
                        stall_left = (r < 41) ? $urandom_range(0, 2) : $urandom_range(9, 49);
                        out_ready <= 1'b0;
                    end
                    else
                        out_ready <= 1'b1;
                end
            end
        end
    end

    function automatic item_t hdr_item(input logic [31:0] mg, input logic [31:0] ver,
                                       input logic [31:0] hdr, input logic [31:0] img,
                                       input logic [31:0] crc, input logic fail);
        item_t it;
        it.op   = OP_HEADER;
        it.mg   = mg;
        it.ver  = ver;
        it.hdr  = hdr;
        it.img  = img;
        it.crc  = crc;
        it.db   = 8'($urandom);
        it.fail = fail;
        return it;
    endfunction

    // header fields are don't-care on data items, so they carry noise
    function automatic item_t data_item(input logic [7:0] db, input logic fail);
        item_t it;
        it.op   = OP_DATA;
        it.mg   = $urandom;
        it.ver  = $urandom;
        it.hdr  = $urandom;
        it.img  = $urandom;
        it.crc  = $urandom;
        it.db   = db;
        it.fail = fail;
        return it;
    endfunction

    task automatic offer(input item_t it, input bit counted);
        int gap;
        int r;
        gap = 0;
        if (!no_gap)
        begin
            if (steady_left > 0)
                steady_left--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    steady_left = $urandom_range(10, 80);
                else if (r >= 60)
                    gap = (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
            end
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= it.op;
        magic        <= it.mg;
        version      <= it.ver;
        header_bytes <= it.hdr;
        image_bytes  <= it.img;
        expected_crc <= it.crc;
        data_byte    <= it.db;
        read_failed  <= it.fail;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (counted)
            sent++;
    endtask

    // valid stays high across back-to-back writes, dropped once at the end
    task automatic program_regs(input logic [31:0] slot, input logic [31:0] mg,
                                input logic [31:0] ver, input logic [31:0] min_word,
                                input logic [31:0] init);
        logic [31:0]          vals [5];
        logic [CFG_IDX_W-1:0] idx  [5];
        vals = '{slot, mg, ver, min_word, init};
        idx  = '{REG_SLOT_SIZE, REG_IMAGE_MAGIC, REG_HDR_VERSION, REG_MIN_HDR, REG_CRC_INIT};
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        slot_cfg  = slot;
        magic_cfg = mg;
        ver_cfg   = ver;
        min_cfg   = min_word[15:0];
        init_cfg  = init;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        // accepted headers and mid-run bytes give no result; let them clear
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // a header with one field changed to break a rule, or a read error, or pure noise
    task automatic bad_header();
        item_t       it;
        logic [31:0] base;
        logic [31:0] lim;
        base = ({16'd0, min_cfg} + 32'd3) & ~32'd3;
        it = hdr_item(magic_cfg, ver_cfg, base, 32'd1, $urandom, 1'b0);
        case ($urandom_range(0, 8))
            0: it.fail = 1'b1;
            1: it.mg = magic_cfg ^ ($urandom | 32'd1);
            2: it.ver = ver_cfg ^ ($urandom | 32'd1);
            3:
            begin
                if (min_cfg != 16'd0)
                    it.hdr = $urandom_range(0, min_cfg - 1);
            end
            4: it.hdr = base + $urandom_range(1, 3);
            5: it.hdr = $urandom_range(slot_cfg, 32'hFFFF_FFFF);
            6: it.img = 32'd0;
            7:
            begin
                lim = slot_cfg - base;
                if (lim != 32'hFFFF_FFFF)
                    it.img = $urandom_range(lim + 32'd1, 32'hFFFF_FFFF);
            end
            default:
            begin
                it.mg   = $urandom;
                it.ver  = $urandom;
                it.hdr  = $urandom;
                it.img  = $urandom;
                it.fail = 1'($urandom_range(0, 1));
            end
        endcase
        offer(it, 1'b1);
    endtask

    // well-formed header followed by its image bytes; some runs are cut short,
    // hit a read error, or carry a wrong CRC; a bad header if none can be well-formed
    task automatic image_run();
        logic [32:0] hdr_lo;
        logic [32:0] hdr_hi;
        logic [32:0] room;
        logic [31:0] hdr;
        logic [31:0] img;
        logic [31:0] crc;
        logic [31:0] fin;
        logic [31:0] crc_field;
        logic [7:0]  image [$];
        int          n;
        int          fail_at;
        int          r;
        hdr_lo = ({17'd0, min_cfg} + 33'd3) & ~33'd3;
        if (slot_cfg <= {16'd0, min_cfg} || hdr_lo >= {1'b0, slot_cfg})
        begin
            bad_header();
            return;
        end
        hdr_hi = ({1'b0, slot_cfg} - 33'd1) & ~33'd3;
        r = $urandom_range(0, 99);
        if (r < 50)
            hdr = hdr_lo[31:0];
        else if (r < 75)
            hdr = hdr_hi[31:0];
        else
            hdr = hdr_lo[31:0] + 32'd4 * $urandom_range(0, 32'((hdr_hi - hdr_lo) >> 2));
        room = {1'b0, slot_cfg} - {1'b0, hdr};
        r = $urandom_range(0, 99);
        if (r < 80)
            img = $urandom_range(1, (room > 12) ? 12 : room[31:0]);
        else if (r < 90)
            img = (room > 48) ? $urandom_range(13, 48) : room[31:0];
        else
            img = room[31:0];
        // huge images are never finished; the next header drops them
        n = (img > 48) ? $urandom_range(1, 24) : int'(img);
        if (n > 1 && $urandom_range(0, 99) < 5)
            n = $urandom_range(1, n - 1);
        fail_at = ($urandom_range(0, 99) < 6) ? $urandom_range(0, n - 1) : -1;
        crc = init_cfg;
        for (int i = 0; i < n; i++)
        begin
            image.push_back(8'($urandom));
            crc = crc ^ {24'd0, image[i]};
            repeat (8) crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'd0);
        end
        fin = crc ^ init_cfg;
        r = $urandom_range(0, 99);
        if (r < 65)
            crc_field = fin;
        else if (r < 85)
            crc_field = fin ^ (32'd1 << $urandom_range(0, 31));
        else
            crc_field = $urandom;
        offer(hdr_item(magic_cfg, ver_cfg, hdr, img, crc_field, 1'b0), 1'b1);
        for (int i = 0; i < n; i++)
        begin
            offer(data_item(image[i], i == fail_at), 1'b1);
            if (i == fail_at)
                break;
        end
    endtask

    task automatic random_phase(input int budget);
        int goal;
        goal = sent + budget;
        while (sent < goal)
        begin
            if ($urandom_range(0, 99) < 72)
                image_run();
            else if ($urandom_range(0, 99) < 60)
                bad_header();
            else
                offer(data_item(8'($urandom), 1'($urandom_range(0, 1))), 1'b0);
            if ($urandom_range(0, 99) < 2)
                drain();
        end
    endtask

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on reset register values
        offer(data_item(8'hFF, 1'b0), 1'b0);
        offer(hdr_item(32'd0, 32'd1, 32'd20, 32'd9, 32'hCBF4_3926, 1'b1), 1'b1);
        offer(hdr_item(32'hFFFF_FFFF, 32'd1, 32'd20, 32'd9, 32'd0, 1'b0), 1'b1);
        offer(hdr_item(32'd0, 32'd0, 32'd20, 32'd9, 32'd0, 1'b0), 1'b1);
        offer(hdr_item(32'd0, 32'd1, 32'd16, 32'd9, 32'd0, 1'b0), 1'b1);
        offer(hdr_item(32'd0, 32'd1, 32'd22, 32'd9, 32'd0, 1'b0), 1'b1);
        offer(hdr_item(32'd0, 32'd1, 32'd65536, 32'd9, 32'd0, 1'b0), 1'b1);
        offer(hdr_item(32'd0, 32'd1, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'd0, 1'b0), 1'b1);
        offer(hdr_item(32'd0, 32'd1, 32'd20, 32'd0, 32'd0, 1'b0), 1'b1);
        offer(hdr_item(32'd0, 32'd1, 32'd20, 32'd65517, 32'd0, 1'b0), 1'b1);
        // standard check string "123456789"
        offer(hdr_item(32'd0, 32'd1, 32'd20, 32'd9, 32'hCBF4_3926, 1'b0), 1'b1);
        for (int i = 0; i < 9; i++)
            offer(data_item(8'h31 + 8'(i), 1'b0), 1'b1);
        // read error in the middle of a run
        offer(hdr_item(32'd0, 32'd1, 32'd65532, 32'd4, 32'd0, 1'b0), 1'b1);
        offer(data_item(8'h00, 1'b0), 1'b1);
        offer(data_item(8'hA5, 1'b1), 1'b1);
        // new header while a run is still open
        offer(hdr_item(32'd0, 32'd1, 32'd20, 32'd2, 32'd0, 1'b0), 1'b1);
        offer(data_item(8'h5A, 1'b0), 1'b1);
        offer(hdr_item(32'd0, 32'd1, 32'd20, 32'd1, 32'd0, 1'b0), 1'b1);
        offer(data_item(8'hFF, 1'b0), 1'b1);

        // hold the result side while a burst of failing headers fills the queue
        no_gap = 1'b1;
        hold_req <= 1'b1;
        repeat (14)
            offer(hdr_item(magic_cfg, ver_cfg, 32'd20, 32'd4, $urandom, 1'b1), 1'b1);
        hold_req <= 1'b0;
        no_gap = 1'b0;
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h0000_FFFF, 32'd0);
                1: program_regs(32'd64, 32'd0, 32'hFFFF_FFFF, 32'd4, 32'hFFFF_FFFF);
                2: program_regs(32'd21, $urandom, $urandom, 32'd20, $urandom);
                // upper half of the min header word is dropped by the register
                3: program_regs(32'h0001_0000, $urandom, $urandom, 32'hABCD_0010, 32'h04C1_1DB7);
                // slot not larger than the minimum header size: every header is rejected
                4: program_regs(32'd20, $urandom, $urandom, 32'd20, $urandom);
                5: program_regs(32'd1, $urandom, $urandom, 32'd4, $urandom);
                default: program_regs($urandom_range(24, 600), $urandom, $urandom,
                                      $urandom_range(4, 40), $urandom);
            endcase
            random_phase((ph == 4 || ph == 5) ? 40 : 350);
            drain();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("image_header_crc_verifier_tb: PASS");
        else
            $display("image_header_crc_verifier_tb: FAIL");
        $finish;
    end

endmodule

/* files.f */
design/ihcv_pkg.sv
design/ihcv_front.sv
design/ihcv_queue.sv
design/ihcv_back.sv
design/image_header_crc_verifier.sv
tb/ihcv_checker.sv
tb/image_header_crc_verifier_tb.sv
